[hdl/sls_pkg.sv]
// shared types and codes for the sorted list store
`timescale 1ns / 1ps

package sls_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int ACTION_W   = 3;
  localparam int IO_VALUE_W = 32;
  localparam int POSITION_W = 6;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 2;

  localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PREPEND = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_APPEND  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REVERSE = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SORT,
    OP_PLACE,
    OP_REMOVE,
    OP_READ
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rev;
  } cell_cmd_t;

endpackage

[hdl/sorted_list_store.sv]
// sorted list store: chain of value cells with ordered insert, remove, reverse and read
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+-------------------
//   in      | action, value, position                  | in_valid/in_ready
//   out     | read_value, entry_count, status,         | out_valid/out_ready
//           | ascending_ok, descending_ok              |
//
// an item passes S_IDLE and S_FLAGS: the cell row updates on acceptance, the order
// flags are gathered from the neighbor compares in S_FLAGS, once the row is registered
// a new item is taken while the previous result still waits in the output register
// a stalled output holds the S_FLAGS state until the output register frees
// reset clears the count and the direction bit; cells need no clearing
`timescale 1ns / 1ps

module sorted_list_store #(
  parameter int DEPTH       = sls_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = sls_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [sls_pkg::ACTION_W-1:0]             action,
  input  logic signed [sls_pkg::IO_VALUE_W-1:0]    value,
  input  logic [sls_pkg::POSITION_W-1:0]           position,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [sls_pkg::IO_VALUE_W-1:0]    read_value,
  output logic [sls_pkg::COUNT_W-1:0]              entry_count,
  output logic [sls_pkg::STATUS_W-1:0]             status,
  output logic                                     ascending_ok,
  output logic                                     descending_ok
);
  import sls_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_FLAGS
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic rev;
  logic rev_next;
  logic in_fire;
  logic out_free;
  logic full;
  logic in_range;
  logic [CNT_W-1:0] phys;
  logic [STATUS_W-1:0] status_next;
  logic [STATUS_W-1:0] pend_status;
  logic signed [IO_VALUE_W-1:0] pend_read;
  cell_cmd_t cmd;
  cell_op_t op_dec;
  logic [IDX_W-1:0] at_idx;
  logic signed [VALUE_WIDTH-1:0] v_ext;
  logic signed [VALUE_WIDTH-1:0] rd_sel;
  logic asc_all;
  logic desc_all;

  logic signed [VALUE_WIDTH-1:0] data_w  [DEPTH];
  logic signed [VALUE_WIDTH-1:0] tap_w   [DEPTH];
  logic signed [VALUE_WIDTH-1:0] left_w  [DEPTH];
  logic signed [VALUE_WIDTH-1:0] right_w [DEPTH];
  logic [DEPTH:0] f_ch;
  logic [DEPTH:0] h_ch;
  logic [DEPTH-1:0] hl_w;
  logic [DEPTH-1:0] asc_w;
  logic [DEPTH-1:0] desc_w;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign v_ext    = VALUE_WIDTH'(value);
  assign full     = count == CNT_W'(DEPTH);
  assign in_range = 32'(position) < 32'(count);
  assign phys     = rev ? (count - CNT_W'(1) - CNT_W'(position)) : CNT_W'(position);

  always_comb begin
    op_dec      = OP_HOLD;
    at_idx      = '0;
    status_next = ST_DONE;
    count_next  = count;
    rev_next    = rev;
    case (action)
      ACT_INSERT: begin
        if (full) status_next = ST_FULL;
        else begin
          op_dec     = OP_SORT;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_PREPEND: begin
        if (full) status_next = ST_FULL;
        else begin
          op_dec     = OP_PLACE;
          at_idx     = rev ? IDX_W'(count) : '0;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_APPEND: begin
        if (full) status_next = ST_FULL;
        else begin
          op_dec     = OP_PLACE;
          at_idx     = rev ? '0 : IDX_W'(count);
          count_next = count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (!in_range) status_next = ST_RANGE;
        else begin
          op_dec     = OP_REMOVE;
          at_idx     = IDX_W'(phys);
          count_next = count - CNT_W'(1);
        end
      end
      ACT_REVERSE: rev_next = !rev;
      ACT_READ: begin
        if (!in_range) status_next = ST_RANGE;
        else begin
          op_dec = OP_READ;
          at_idx = IDX_W'(phys);
        end
      end
      default: op_dec = OP_HOLD;
    endcase
    cmd.op  = in_fire ? op_dec : OP_HOLD;
    cmd.rev = rev;
  end

  assign f_ch[0]     = 1'b0;
  assign h_ch[DEPTH] = 1'b0;

  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    if (p == 0) begin : g_first
      assign left_w[p] = data_w[p];
      assign hl_w[p]   = 1'b1;
    end else begin : g_mid
      assign left_w[p] = data_w[p-1];
      assign hl_w[p]   = h_ch[p-1];
    end
    if (p == DEPTH - 1) begin : g_last
      assign right_w[p] = data_w[p];
    end else begin : g_inner
      assign right_w[p] = data_w[p+1];
    end

    sls_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DEPTH       (DEPTH),
      .INDEX       (p)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .in_value   (v_ext),
      .at         (at_idx),
      .count      (count),
      .left_data  (left_w[p]),
      .right_data (right_w[p]),
      .f_in       (f_ch[p]),
      .h_in       (h_ch[p+1]),
      .hl_in      (hl_w[p]),
      .f_out      (f_ch[p+1]),
      .h_out      (h_ch[p]),
      .data       (data_w[p]),
      .tap_data   (tap_w[p]),
      .asc_ok     (asc_w[p]),
      .desc_ok    (desc_w[p])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) rd_sel = rd_sel | tap_w[i];
  end

  assign asc_all  = &asc_w;
  assign desc_all = &desc_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rev       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && out_ready) out_valid <= 1'b0;
          if (in_fire) begin
            count       <= count_next;
            rev         <= rev_next;
            pend_status <= status_next;
            pend_read   <= IO_VALUE_W'(rd_sel);
            state       <= S_FLAGS;
          end
        end
        S_FLAGS: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            read_value    <= pend_read;
            entry_count   <= COUNT_W'(count);
            status        <= pend_status;
            ascending_ok  <= rev ? desc_all : asc_all;
            descending_ok <= rev ? asc_all : desc_all;
            state         <= S_IDLE;
          end
        end
        default: begin
          if (out_valid && out_ready) out_valid <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count past depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    in_fire && full && (action == ACT_INSERT || action == ACT_PREPEND ||
    action == ACT_APPEND) |=> count == $past(count))
    else $error("add to full store changed the count");

  a_reverse: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == ACT_REVERSE |=> count == $past(count) && rev != $past(rev))
    else $error("reverse did not flip direction only");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    state == S_FLAGS && out_free |=> out_valid && state == S_IDLE)
    else $error("result not loaded when output was free");
`endif

endmodule

[hdl/sls_cell.sv]
// one storage cell of the list chain
`timescale 1ns / 1ps

module sls_cell #(
  parameter int VALUE_WIDTH = sls_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH       = sls_pkg::DEPTH_DEF,
  parameter int INDEX       = 0
) (
  input  logic                            clk,
  input  sls_pkg::cell_cmd_t              cmd,
  input  logic signed [VALUE_WIDTH-1:0]   in_value,
  input  logic [$clog2(DEPTH)-1:0]        at,
  input  logic [$clog2(DEPTH+1)-1:0]      count,
  input  logic signed [VALUE_WIDTH-1:0]   left_data,
  input  logic signed [VALUE_WIDTH-1:0]   right_data,
  input  logic                            f_in,
  input  logic                            h_in,
  input  logic                            hl_in,
  output logic                            f_out,
  output logic                            h_out,
  output logic signed [VALUE_WIDTH-1:0]   data,
  output logic signed [VALUE_WIDTH-1:0]   tap_data,
  output logic                            asc_ok,
  output logic                            desc_ok
);
  import sls_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [VALUE_WIDTH-1:0] entry;
  logic signed [VALUE_WIDTH-1:0] entry_next;
  logic valid;
  logic greater;
  logic at_match;
  logic at_above;

  assign valid    = CNT_W'(INDEX) < count;
  assign greater  = entry > in_value;
  assign at_match = at == IDX_W'(INDEX);
  assign at_above = IDX_W'(INDEX) > at;

  // prefix chains locate the sorted insert point in either direction
  assign f_out = f_in | ~valid | greater;
  assign h_out = h_in | (valid & greater);

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      OP_SORT: begin
        if (!cmd.rev) begin
          if (f_in) entry_next = left_data;
          else if (f_out) entry_next = in_value;
        end else begin
          if (!hl_in) entry_next = left_data;
          else if (!h_out) entry_next = in_value;
        end
      end
      OP_PLACE: begin
        if (at_above) entry_next = left_data;
        else if (at_match) entry_next = in_value;
      end
      OP_REMOVE: begin
        if (at_match || at_above) entry_next = right_data;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign data     = entry;
  assign tap_data = (cmd.op == OP_READ && at_match) ? entry : '0;
  assign asc_ok   = (INDEX == 0) || !valid || (left_data <= entry);
  assign desc_ok  = (INDEX == 0) || !valid || (entry <= left_data);

endmodule

[sim/sorted_list_store_test.sv]
// self-checking testbench for the sorted list store
`timescale 1ns / 1ps

module sorted_list_store_test;
  import sls_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1025;
  localparam int TAIL_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 23;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef enum int { PH_FILL, PH_MIXED, PH_DRAIN, PH_NOISE } phase_t;

  typedef struct {
    logic signed [IO_VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]           entry_count;
    logic [STATUS_W-1:0]          status;
    logic                         ascending_ok;
    logic                         descending_ok;
  } list_result_t;

  class list_scoreboard;
    logic signed [IO_VALUE_W-1:0] held [LIST_DEPTH];
    int held_count;
    list_result_t pending_outcomes[$];
    int mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function int stored();
      return held_count;
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // apply one accepted item to the shadow list and queue its outcome
    task note_action(logic [ACTION_W-1:0] act, logic signed [IO_VALUE_W-1:0] val,
                     logic [POSITION_W-1:0] pos);
      list_result_t r;
      int slot;
      int lo;
      int hi;
      logic signed [IO_VALUE_W-1:0] swap;
      r.read_value = '0;
      r.status = ST_DONE;
      case (act)
        ACT_INSERT, ACT_PREPEND, ACT_APPEND: begin
          if (held_count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            if (act == ACT_PREPEND) begin
              slot = 0;
            end else if (act == ACT_APPEND) begin
              slot = held_count;
            end else begin
              slot = 0;
              while (slot < held_count && held[slot] <= val) slot++;
            end
            for (int i = held_count; i > slot; i--) held[i] = held[i-1];
            held[slot] = val;
            held_count++;
          end
        end
        ACT_REMOVE: begin
          if (int'(pos) >= held_count) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = int'(pos); i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
          end
        end
        ACT_REVERSE: begin
          lo = 0;
          hi = held_count - 1;
          while (lo < hi) begin
            swap = held[lo];
            held[lo] = held[hi];
            held[hi] = swap;
            lo++;
            hi--;
          end
        end
        ACT_READ: begin
          if (int'(pos) >= held_count) r.status = ST_RANGE;
          else r.read_value = held[pos];
        end
        default: ;
      endcase
      r.ascending_ok = 1'b1;
      r.descending_ok = 1'b1;
      for (int i = 1; i < held_count; i++) begin
        if (held[i-1] > held[i]) r.ascending_ok = 1'b0;
        if (held[i] > held[i-1]) r.descending_ok = 1'b0;
      end
      r.entry_count = held_count[COUNT_W-1:0];
      pending_outcomes = {pending_outcomes, r};
    endtask

    task check_result(logic signed [IO_VALUE_W-1:0] rd, logic [COUNT_W-1:0] cnt,
                      logic [STATUS_W-1:0] st, logic asc, logic desc);
      list_result_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      want = pending_outcomes.pop_front();
      if (rd !== want.read_value)
        report_mismatch($sformatf("read_value got %0d want %0d", rd, want.read_value));
      if (cnt !== want.entry_count)
        report_mismatch($sformatf("entry_count got %0d want %0d", cnt, want.entry_count));
      if (st !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", st, want.status));
      if (asc !== want.ascending_ok)
        report_mismatch($sformatf("ascending_ok got %0b want %0b", asc, want.ascending_ok));
      if (desc !== want.descending_ok)
        report_mismatch($sformatf("descending_ok got %0b want %0b", desc, want.descending_ok));
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [ACTION_W-1:0] action;
  logic signed [IO_VALUE_W-1:0] value;
  logic [POSITION_W-1:0] position;
  logic out_valid;
  logic out_ready;
  logic signed [IO_VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0] entry_count;
  logic [STATUS_W-1:0] status;
  logic ascending_ok;
  logic descending_ok;

  logic steady;
  int useful_sent;
  int cycle_count;
  list_scoreboard board = new();

  sorted_list_store u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .value         (value),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_value    (read_value),
    .entry_count   (entry_count),
    .status        (status),
    .ascending_ok  (ascending_ok),
    .descending_ok (descending_ok)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [ACTION_W-1:0] act, logic signed [IO_VALUE_W-1:0] val,
                           logic [POSITION_W-1:0] pos);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    value = val;
    position = pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_action(act, val, pos);
    if (act <= ACT_READ) useful_sent++;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic signed [IO_VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return int'($urandom_range(8)) - 4;
      7: begin
        case ($urandom_range(3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(2000)) - 1000;
    endcase
  endfunction

  function automatic logic [POSITION_W-1:0] pick_position();
    if (board.stored() > 0 && $urandom_range(9) != 0)
      return POSITION_W'($urandom_range(board.stored() - 1));
    return POSITION_W'($urandom_range(63));
  endfunction

  function automatic logic [ACTION_W-1:0] pick_add(int style);
    int r;
    r = $urandom_range(99);
    if (style == 0) return ACT_INSERT;
    if (style == 2) return (r < 50) ? ACT_PREPEND : ACT_APPEND;
    if (r < 60) return ACT_INSERT;
    return (r < 80) ? ACT_PREPEND : ACT_APPEND;
  endfunction

  task automatic random_item(phase_t ph, int style);
    logic [ACTION_W-1:0] act;
    int r;
    r = $urandom_range(99);
    case (ph)
      PH_FILL: act = (r < 75) ? pick_add(style) : (r < 85) ? ACT_READ :
                     (r < 92) ? ACT_REVERSE : ACT_REMOVE;
      PH_DRAIN: act = (r < 65) ? ACT_REMOVE : (r < 80) ? ACT_READ :
                      (r < 88) ? ACT_REVERSE : pick_add(style);
      PH_MIXED: act = ACTION_W'($urandom_range(5));
      default: act = ACTION_W'($urandom_range(7));
    endcase
    if (ph == PH_NOISE) send_item(act, $urandom, POSITION_W'($urandom_range(63)));
    else send_item(act, pick_value(), pick_position());
  endtask

  initial begin
    sorted_list_store_test.in_valid = 1'b0;
    action = ACT_INSERT;
    value = '0;
    position = '0;
    out_ready = 1'b0;
    steady = 1'b0;
    useful_sent = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store corners
    send_item(ACT_READ, 0, 0);
    send_item(ACT_REMOVE, 0, 6'd63);
    send_item(ACT_REVERSE, 0, 0);
    send_item(ACT_SPARE_LO, 32'sh7fffffff, 6'd63);
    send_item(ACT_SPARE_HI, 32'sh80000000, 6'd0);
    // extremes, equal values and order breaks
    send_item(ACT_INSERT, 32'sh7fffffff, 0);
    send_item(ACT_INSERT, 32'sh80000000, 0);
    send_item(ACT_INSERT, 0, 0);
    send_item(ACT_READ, 0, 6'd0);
    send_item(ACT_INSERT, 0, 0);
    send_item(ACT_PREPEND, 5, 0);
    send_item(ACT_APPEND, -1, 0);
    send_item(ACT_READ, 0, 6'd5);
    send_item(ACT_READ, 0, 6'd6);
    send_item(ACT_REVERSE, 0, 0);
    send_item(ACT_READ, 0, 6'd0);
    send_item(ACT_REMOVE, 0, 6'd0);
    send_item(ACT_REMOVE, 0, 6'd4);
    send_item(ACT_REMOVE, 0, 6'd2);
    send_item(ACT_REVERSE, 0, 0);
    send_item(ACT_READ, 0, 6'd63);
    wait_all_results();

    for (int phase_no = 0; useful_sent < RANDOM_ITEMS + 21; phase_no++) begin
      phase_t ph;
      int style;
      int extra;
      int guard;
      ph = phase_t'(phase_no % 4);
      style = $urandom_range(2);
      steady = (phase_no == 1) || ($urandom_range(4) == 0);
      guard = 0;
      case (ph)
        PH_FILL: begin
          while (board.stored() < LIST_DEPTH && guard < 400) begin
            random_item(ph, style);
            guard++;
          end
          extra = $urandom_range(6, 2);
          repeat (extra) send_item(pick_add(1), pick_value(), pick_position());
        end
        PH_DRAIN: begin
          while (board.stored() > 0 && guard < 400) begin
            random_item(ph, style);
            guard++;
          end
          extra = $urandom_range(4, 1);
          repeat (extra) send_item(($urandom_range(1) != 0) ? ACT_REMOVE : ACT_READ, 0,
                                   POSITION_W'($urandom_range(63)));
        end
        PH_MIXED: repeat (40) random_item(ph, style);
        default: repeat (15) random_item(ph, style);
      endcase
      if ($urandom_range(2) == 0) wait_all_results();
    end

    steady = 1'b0;
    in_valid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0) $display("** sorted_list_store: PASSED **");
    else $display("** sorted_list_store: FAILED **");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(read_value, entry_count, status, ascending_ok, descending_ok);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** sorted_list_store: FAILED **");
    $finish;
  end

endmodule

[sorted_list_store.f]
hdl/sls_pkg.sv
hdl/sls_cell.sv
hdl/sorted_list_store.sv
sim/sorted_list_store_test.sv
